// ===== hdl/mrs_pkg.sv =====
// shared constants, types and crc helper for the modbus rtu slave
`timescale 1ns / 1ps
package mrs_pkg;

  localparam int FRAME_BYTES = 256;
  localparam int REG_COUNT   = 64;
  localparam int FB_AW       = $clog2(FRAME_BYTES);
  localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
  localparam int REG_AW      = $clog2(REG_COUNT);

  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_GAP   = 2'd1;
  localparam logic [1:0] REQ_INREG = 2'd2;

  localparam logic [7:0] FC_RD_HOLD  = 8'd3;
  localparam logic [7:0] FC_RD_INPUT = 8'd4;
  localparam logic [7:0] FC_WR_ONE   = 8'd6;
  localparam logic [7:0] FC_WR_MULTI = 8'd16;

  localparam logic [7:0] EXC_FUNC  = 8'd1;
  localparam logic [7:0] EXC_ADDR  = 8'd2;
  localparam logic [7:0] EXC_VALUE = 8'd3;
  localparam logic [7:0] EXC_FLAG  = 8'h80;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [15:0] MAX_RD_COUNT = 16'd125;
  localparam logic [15:0] MAX_WR_COUNT = 16'd123;
  localparam logic [LEN_W-1:0] MIN_FRAME = LEN_W'(4);

  typedef struct packed {
    logic       valid;
    logic       eof;
    logic [7:0] data;
  } push_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/mrs_if.sv =====
// handshake channels for request items and response chunks
`timescale 1ns / 1ps
interface mrs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  rx_byte;
  logic [5:0]  input_reg_index;
  logic [15:0] input_reg_value;
  modport source (output valid, req_type, rx_byte, input_reg_index, input_reg_value,
                  input ready);
  modport sink (input valid, req_type, rx_byte, input_reg_index, input_reg_value,
                output ready);
endinterface

interface mrs_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] tx_chunk;
  logic [3:0]  tx_chunk_bytes;
  logic        tx_last;
  modport source (output valid, tx_chunk, tx_chunk_bytes, tx_last, input ready);
  modport sink (input valid, tx_chunk, tx_chunk_bytes, tx_last, output ready);
endinterface

// ===== hdl/mrs_tx_pack.sv =====
// packs response bytes into chunks and appends the frame crc
`timescale 1ns / 1ps
module mrs_tx_pack import mrs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  push_ready_o,
  mrs_rsp_if.source rsp_o
);

  logic [63:0] word_q, word_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [1:0]  tail_q, tail_d;
  logic        fin_q, fin_d;
  logic        ov_q, ov_d;
  logic [63:0] ow_q, ow_d;
  logic [3:0]  on_q, on_d;
  logic        ol_q, ol_d;

  logic       slot_free;
  logic       ins;
  logic [7:0] ins_byte;

  assign push_ready_o = (tail_q == 2'd0) && !fin_q && !cnt_q[3];
  assign slot_free    = !ov_q || rsp_o.ready;

  always_comb begin
    word_d = word_q;
    cnt_d  = cnt_q;
    crc_d  = crc_q;
    tail_d = tail_q;
    fin_d  = fin_q;
    ov_d   = ov_q && !rsp_o.ready;
    ow_d   = ow_q;
    on_d   = on_q;
    ol_d   = ol_q;
    ins      = 1'b0;
    ins_byte = push_i.data;

    if (tail_q == 2'd1) begin
      ins      = !cnt_q[3];
      ins_byte = crc_q[7:0];
    end else if (tail_q == 2'd2) begin
      ins      = !cnt_q[3];
      ins_byte = crc_q[15:8];
    end else if (push_i.valid && push_ready_o) begin
      if (push_i.eof) begin
        tail_d = 2'd1;
      end else begin
        ins   = 1'b1;
        crc_d = crc16_byte(crc_q, push_i.data);
      end
    end

    if (ins) begin
      word_d[{cnt_q[2:0], 3'b000} +: 8] = ins_byte;
      cnt_d = cnt_q + 4'd1;
      if (tail_q == 2'd1) begin
        tail_d = 2'd2;
      end else if (tail_q == 2'd2) begin
        tail_d = 2'd0;
        fin_d  = 1'b1;
      end
    end

    // a full chunk with crc bytes still to come is never the last
    if (cnt_q[3] && !fin_q && slot_free) begin
      ov_d   = 1'b1;
      ow_d   = word_q;
      on_d   = cnt_q;
      ol_d   = 1'b0;
      word_d = '0;
      cnt_d  = 4'd0;
    end else if (fin_q && slot_free) begin
      ov_d   = 1'b1;
      ow_d   = word_q;
      on_d   = cnt_q;
      ol_d   = 1'b1;
      word_d = '0;
      cnt_d  = 4'd0;
      fin_d  = 1'b0;
      crc_d  = CRC_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      cnt_q  <= 4'd0;
      crc_q  <= CRC_INIT;
      tail_q <= 2'd0;
      fin_q  <= 1'b0;
      ov_q   <= 1'b0;
      ow_q   <= '0;
      on_q   <= 4'd0;
      ol_q   <= 1'b0;
    end else begin
      word_q <= word_d;
      cnt_q  <= cnt_d;
      crc_q  <= crc_d;
      tail_q <= tail_d;
      fin_q  <= fin_d;
      ov_q   <= ov_d;
      ow_q   <= ow_d;
      on_q   <= on_d;
      ol_q   <= ol_d;
    end
  end

  assign rsp_o.valid          = ov_q;
  assign rsp_o.tx_chunk       = ow_q;
  assign rsp_o.tx_chunk_bytes = on_q;
  assign rsp_o.tx_last        = ol_q;

endmodule

// ===== hdl/modbus_rtu_slave_frame_engine.sv =====
// modbus rtu slave: frame buffer, request decode and register stores
// a received byte or input register update is taken while idle; ready drops while a frame is served
// a gap scans the buffer one byte a cycle, then writes each register from two buffered bytes
// or reads each register before pushing its two bytes; response chunks leave at most one per cycle
// the frame buffer memory sets the pace of the scan and of multiple writes
// reset: register stores read zero through per-entry valid bits, frame length 0, address 1
`timescale 1ns / 1ps
module modbus_rtu_slave_frame_engine import mrs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  mrs_req_if.sink    req_i,
  mrs_rsp_if.source  rsp_o
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SCAN   = 9'b000000010,
    ST_DECIDE = 9'b000000100,
    ST_WRMUL  = 9'b000001000,
    ST_HDR    = 9'b000010000,
    ST_RDADDR = 9'b000100000,
    ST_RDHI   = 9'b001000000,
    ST_RDLO   = 9'b010000000,
    ST_EOF    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]       addr_q;
  logic [LEN_W-1:0] flen_q, flen_d;
  logic [LEN_W-1:0] glen_q, glen_d;
  logic [LEN_W-1:0] ptr_q, ptr_d;
  logic [LEN_W-1:0] ridx_q;
  logic [LEN_W-1:0] end_q, end_d;
  logic             rv_q;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       a_q, a_d, fc_q, fc_d;
  logic [7:0]       b2_q, b2_d, b3_q, b3_d, b4_q, b4_d, b5_q, b5_d, b6_q, b6_d;
  logic [7:0]       clo_q, clo_d, chi_q, chi_d;
  logic [7:0]       hdr_q [6];
  logic [7:0]       hdr_d [6];
  logic [2:0]       hn_q, hn_d, hi_q, hi_d;
  logic             rdmode_q, rdmode_d;
  logic             bc_q, bc_d;
  logic [REG_AW-1:0] rptr_q, rptr_d, wptr_q, wptr_d;
  logic [REG_AW:0]   rem_q, rem_d;
  logic [7:0]       hib_q, hib_d;

  // memories
  logic [7:0]  fbuf [FRAME_BYTES];
  logic [15:0] hreg [REG_COUNT];
  logic [15:0] ireg [REG_COUNT];
  logic [REG_COUNT-1:0] hv_q, iv_q;
  logic [7:0]  fb_rd_q;
  logic [15:0] h_rd_q, i_rd_q;
  logic        h_rv_q, i_rv_q;

  logic             fb_we;
  logic [FB_AW-1:0] fb_wa;
  logic             h_we;
  logic [REG_AW-1:0] h_wa;
  logic [15:0]      h_wd;
  logic             i_we;
  logic             issue;
  logic             reg_re;
  logic [15:0]      reg_val;

  push_t push;
  logic  push_ready;

  logic             accept;
  logic [15:0]      start16, cnt16;
  logic [16:0]      sum17;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign start16     = {b2_q, b3_q};
  assign cnt16       = {b4_q, b5_q};
  assign sum17       = {1'b0, start16} + {1'b0, cnt16};
  assign reg_val     = (fc_q == FC_RD_HOLD) ? (h_rv_q ? h_rd_q : 16'd0)
                                            : (i_rv_q ? i_rd_q : 16'd0);

  always_comb begin
    logic        resp;
    logic        exc;
    logic [7:0]  code;
    logic        bc;
    state_d  = state_q;
    flen_d   = flen_q;
    glen_d   = glen_q;
    ptr_d    = ptr_q;
    end_d    = end_q;
    crc_d    = crc_q;
    a_d = a_q; fc_d = fc_q;
    b2_d = b2_q; b3_d = b3_q; b4_d = b4_q; b5_d = b5_q; b6_d = b6_q;
    clo_d = clo_q; chi_d = chi_q;
    hdr_d    = hdr_q;
    hn_d     = hn_q;
    hi_d     = hi_q;
    rdmode_d = rdmode_q;
    bc_d     = bc_q;
    rptr_d   = rptr_q;
    wptr_d   = wptr_q;
    rem_d    = rem_q;
    hib_d    = hib_q;
    fb_we    = 1'b0;
    fb_wa    = flen_q[FB_AW-1:0];
    h_we     = 1'b0;
    h_wa     = wptr_q;
    h_wd     = {hib_q, fb_rd_q};
    i_we     = 1'b0;
    issue    = 1'b0;
    reg_re   = 1'b0;
    push     = '0;
    resp     = 1'b0;
    exc      = 1'b0;
    code     = EXC_VALUE;
    bc       = (a_q == 8'd0);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.req_type == REQ_BYTE) begin
            if (flen_q < LEN_W'(FRAME_BYTES)) begin
              fb_we  = 1'b1;
              flen_d = flen_q + LEN_W'(1);
            end else begin
              flen_d = '0;
            end
          end else if (req_i.req_type == REQ_INREG) begin
            i_we = ({1'b0, req_i.input_reg_index} < 7'(REG_COUNT));
          end else if (req_i.req_type == REQ_GAP) begin
            flen_d = '0;
            glen_d = flen_q;
            ptr_d  = '0;
            crc_d  = CRC_INIT;
            if (flen_q >= MIN_FRAME) begin
              state_d = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        issue = (ptr_q < glen_q);
        if (issue) begin
          ptr_d = ptr_q + LEN_W'(1);
        end
        if (rv_q) begin
          if (ridx_q < glen_q - LEN_W'(2)) begin
            crc_d = crc16_byte(crc_q, fb_rd_q);
          end
          unique case (ridx_q)
            LEN_W'(0): a_d  = fb_rd_q;
            LEN_W'(1): fc_d = fb_rd_q;
            LEN_W'(2): b2_d = fb_rd_q;
            LEN_W'(3): b3_d = fb_rd_q;
            LEN_W'(4): b4_d = fb_rd_q;
            LEN_W'(5): b5_d = fb_rd_q;
            LEN_W'(6): b6_d = fb_rd_q;
            default: ;
          endcase
          if (ridx_q == glen_q - LEN_W'(2)) clo_d = fb_rd_q;
          if (ridx_q == glen_q - LEN_W'(1)) begin
            chi_d   = fb_rd_q;
            state_d = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        state_d  = ST_IDLE;
        bc_d     = bc;
        rdmode_d = 1'b0;
        hdr_d[0] = a_q;
        hdr_d[1] = fc_q;
        hdr_d[2] = b2_q;
        hdr_d[3] = b3_q;
        hdr_d[4] = b4_q;
        hdr_d[5] = b5_q;
        hn_d     = 3'd6;
        hi_d     = 3'd0;
        if ((bc || a_q == addr_q) && crc_q == {chi_q, clo_q}) begin
          if (fc_q == FC_RD_HOLD || fc_q == FC_RD_INPUT) begin
            if (!bc) begin
              if (glen_q < LEN_W'(8) || cnt16 == 16'd0 || cnt16 > MAX_RD_COUNT) begin
                exc = 1'b1;
              end else if (sum17 > 17'(REG_COUNT)) begin
                exc  = 1'b1;
                code = EXC_ADDR;
              end else begin
                resp     = 1'b1;
                rdmode_d = 1'b1;
                hdr_d[2] = {cnt16[6:0], 1'b0};
                hn_d     = 3'd3;
                rptr_d   = start16[REG_AW-1:0];
                rem_d    = cnt16[REG_AW:0];
              end
            end
          end else if (fc_q == FC_WR_ONE) begin
            if (glen_q < LEN_W'(8)) begin
              exc = !bc;
            end else if (start16 >= 16'(REG_COUNT)) begin
              exc  = !bc;
              code = EXC_ADDR;
            end else begin
              h_we = 1'b1;
              h_wa = start16[REG_AW-1:0];
              h_wd = cnt16;
              resp = !bc;
            end
          end else if (fc_q == FC_WR_MULTI) begin
            if (glen_q < LEN_W'(9) || cnt16 == 16'd0 || cnt16 > MAX_WR_COUNT ||
                {9'd0, b6_q} != {cnt16, 1'b0} ||
                {1'b0, glen_q} < 10'd9 + {2'b00, b6_q}) begin
              exc = !bc;
            end else if (sum17 > 17'(REG_COUNT)) begin
              exc  = !bc;
              code = EXC_ADDR;
            end else begin
              state_d = ST_WRMUL;
              ptr_d   = LEN_W'(7);
              end_d   = LEN_W'(7) + {cnt16[LEN_W-2:0], 1'b0};
              wptr_d  = start16[REG_AW-1:0];
            end
          end else begin
            exc  = !bc;
            code = EXC_FUNC;
          end
        end
        if (exc) begin
          hdr_d[1] = fc_q | EXC_FLAG;
          hdr_d[2] = code;
          hn_d     = 3'd3;
          state_d  = ST_HDR;
        end else if (resp) begin
          state_d = ST_HDR;
        end
      end

      ST_WRMUL: begin
        issue = (ptr_q < end_q);
        if (issue) begin
          ptr_d = ptr_q + LEN_W'(1);
        end
        fb_wa = ptr_q[FB_AW-1:0];
        // odd offsets carry the high byte of each register value
        if (rv_q) begin
          if (ridx_q[0]) begin
            hib_d = fb_rd_q;
          end else begin
            h_we   = 1'b1;
            wptr_d = wptr_q + REG_AW'(1);
          end
          if (ridx_q == end_q - LEN_W'(1)) begin
            state_d = bc_q ? ST_IDLE : ST_HDR;
          end
        end
      end

      ST_HDR: begin
        push.valid = 1'b1;
        push.data  = hdr_q[hi_q];
        if (push_ready) begin
          hi_d = hi_q + 3'd1;
          if (hi_q + 3'd1 == hn_q) begin
            state_d = rdmode_q ? ST_RDADDR : ST_EOF;
          end
        end
      end

      ST_RDADDR: begin
        reg_re  = 1'b1;
        state_d = ST_RDHI;
      end

      ST_RDHI: begin
        push.valid = 1'b1;
        push.data  = reg_val[15:8];
        if (push_ready) state_d = ST_RDLO;
      end

      ST_RDLO: begin
        push.valid = 1'b1;
        push.data  = reg_val[7:0];
        if (push_ready) begin
          rptr_d  = rptr_q + REG_AW'(1);
          rem_d   = rem_q - (REG_AW+1)'(1);
          state_d = (rem_q == (REG_AW+1)'(1)) ? ST_EOF : ST_RDADDR;
        end
      end

      ST_EOF: begin
        push.valid = 1'b1;
        push.eof   = 1'b1;
        if (push_ready) state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase

    if (state_q == ST_SCAN) fb_wa = ptr_q[FB_AW-1:0];
  end

  // frame buffer: write on received beats, one read a cycle
  always_ff @(posedge clk_i) begin
    if (fb_we) fbuf[fb_wa] <= req_i.rx_byte;
    fb_rd_q <= fbuf[fb_wa];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) hreg[h_wa] <= h_wd;
    if (reg_re) h_rd_q <= hreg[rptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (i_we) ireg[req_i.input_reg_index] <= req_i.input_reg_value;
    if (reg_re) i_rd_q <= ireg[rptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q   <= '0;
      iv_q   <= '0;
      h_rv_q <= 1'b0;
      i_rv_q <= 1'b0;
    end else begin
      if (h_we) hv_q[h_wa] <= 1'b1;
      if (i_we) iv_q[req_i.input_reg_index] <= 1'b1;
      if (reg_re) begin
        h_rv_q <= hv_q[rptr_q];
        i_rv_q <= iv_q[rptr_q];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      addr_q   <= 8'd1;
      flen_q   <= '0;
      glen_q   <= '0;
      ptr_q    <= '0;
      ridx_q   <= '0;
      end_q    <= '0;
      rv_q     <= 1'b0;
      crc_q    <= CRC_INIT;
      a_q <= '0; fc_q <= '0;
      b2_q <= '0; b3_q <= '0; b4_q <= '0; b5_q <= '0; b6_q <= '0;
      clo_q <= '0; chi_q <= '0;
      hdr_q    <= '{default: '0};
      hn_q     <= '0;
      hi_q     <= '0;
      rdmode_q <= 1'b0;
      bc_q     <= 1'b0;
      rptr_q   <= '0;
      wptr_q   <= '0;
      rem_q    <= '0;
      hib_q    <= '0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) addr_q <= cfg_wdata_i;
      flen_q   <= flen_d;
      glen_q   <= glen_d;
      ptr_q    <= ptr_d;
      ridx_q   <= ptr_q;
      end_q    <= end_d;
      rv_q     <= issue;
      crc_q    <= crc_d;
      a_q <= a_d; fc_q <= fc_d;
      b2_q <= b2_d; b3_q <= b3_d; b4_q <= b4_d; b5_q <= b5_d; b6_q <= b6_d;
      clo_q <= clo_d; chi_q <= chi_d;
      hdr_q    <= hdr_d;
      hn_q     <= hn_d;
      hi_q     <= hi_d;
      rdmode_q <= rdmode_d;
      bc_q     <= bc_d;
      rptr_q   <= rptr_d;
      wptr_q   <= wptr_d;
      rem_q    <= rem_d;
      hib_q    <= hib_d;
    end
  end

  mrs_tx_pack u_tx_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .rsp_o        (rsp_o)
  );

endmodule

// ===== test/tb.sv =====
// self-checking regression of the modbus rtu slave frame engine
`timescale 1ns / 1ps
module tb import mrs_pkg::*; ();

  typedef struct {
    logic [63:0] chunk;
    logic [3:0]  nbytes;
    logic        last;
  } chunk_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = 8'd1;
  bit calm = 1'b0;
  int errors = 0;

  mrs_req_if req_ch();
  mrs_rsp_if rsp_ch();

  modbus_rtu_slave_frame_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req_i(req_ch.sink), .rsp_o(rsp_ch.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("modbus_rtu_slave_frame_engine regression: fail");
    $finish;
  end

  // predictor state
  logic [7:0]  fbuf[FRAME_BYTES];
  int          flen;
  logic [15:0] hold_regs[REG_COUNT];
  logic [15:0] in_regs[REG_COUNT];
  logic [7:0]  own_addr;
  chunk_t      pending_chunks[$];

  function automatic logic [15:0] crc_of(input logic [7:0] b[$]);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (b[i]) begin
      c = c ^ {8'h00, b[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] word_at(input int i);
    return {fbuf[i], fbuf[i+1]};
  endfunction

  function automatic void serve_frame(input int len, ref logic [7:0] tx[$]);
    logic [7:0] a, fc, bcnt;
    logic [7:0] body[$];
    logic bc;
    int start, count;
    tx = {};
    a = fbuf[0];
    bc = (a == 8'd0);
    if (!bc && a != own_addr) return;
    for (int i = 0; i < len - 2; i++) body.push_back(fbuf[i]);
    if (crc_of(body) != {fbuf[len-1], fbuf[len-2]}) return;
    fc = fbuf[1];
    if (fc == FC_RD_HOLD || fc == FC_RD_INPUT) begin
      if (bc) return;
      if (len < 8) begin tx = {a, fc | EXC_FLAG, EXC_VALUE}; return; end
      start = word_at(2);
      count = word_at(4);
      if (count == 0 || count > 125) begin tx = {a, fc | EXC_FLAG, EXC_VALUE}; return; end
      if (start + count > REG_COUNT) begin tx = {a, fc | EXC_FLAG, EXC_ADDR}; return; end
      tx = {a, fc, 8'(count * 2)};
      for (int i = 0; i < count; i++) begin
        logic [15:0] v;
        v = (fc == FC_RD_HOLD) ? hold_regs[start+i] : in_regs[start+i];
        tx.push_back(v[15:8]);
        tx.push_back(v[7:0]);
      end
    end else if (fc == FC_WR_ONE) begin
      if (len < 8) begin if (!bc) tx = {a, fc | EXC_FLAG, EXC_VALUE}; return; end
      start = word_at(2);
      if (start >= REG_COUNT) begin if (!bc) tx = {a, fc | EXC_FLAG, EXC_ADDR}; return; end
      hold_regs[start] = word_at(4);
      if (bc) return;
      tx = {a, fbuf[1], fbuf[2], fbuf[3], fbuf[4], fbuf[5]};
    end else if (fc == FC_WR_MULTI) begin
      if (len < 9) begin if (!bc) tx = {a, fc | EXC_FLAG, EXC_VALUE}; return; end
      start = word_at(2);
      count = word_at(4);
      bcnt = fbuf[6];
      if (count == 0 || count > 123 || bcnt != count * 2 || len < 9 + bcnt) begin
        if (!bc) tx = {a, fc | EXC_FLAG, EXC_VALUE};
        return;
      end
      if (start + count > REG_COUNT) begin if (!bc) tx = {a, fc | EXC_FLAG, EXC_ADDR}; return; end
      for (int i = 0; i < count; i++) hold_regs[start+i] = word_at(7 + 2 * i);
      if (bc) return;
      tx = {a, fc, fbuf[2], fbuf[3], fbuf[4], fbuf[5]};
    end else if (!bc) begin
      tx = {a, fc | EXC_FLAG, EXC_FUNC};
    end
  endfunction

  function automatic void predict_item(input logic [1:0] rt, input logic [7:0] b,
                                       input logic [5:0] idx, input logic [15:0] val);
    logic [7:0] tx[$];
    logic [15:0] c;
    chunk_t ch;
    int len, pos;
    if (rt == REQ_BYTE) begin
      if (flen < FRAME_BYTES) begin fbuf[flen] = b; flen++; end
      else flen = 0;
    end else if (rt == REQ_INREG) begin
      in_regs[idx] = val;
    end else if (rt == REQ_GAP) begin
      len = flen;
      flen = 0;
      if (len < 4) return;
      serve_frame(len, tx);
      if (tx.size() == 0) return;
      c = crc_of(tx);
      tx.push_back(c[7:0]);
      tx.push_back(c[15:8]);
      pos = 0;
      while (pos < tx.size()) begin
        ch.chunk = '0;
        ch.nbytes = 0;
        for (int j = 0; j < 8 && pos < tx.size(); j++) begin
          ch.chunk[8*j +: 8] = tx[pos];
          pos++;
          ch.nbytes++;
        end
        ch.last = (pos == tx.size());
        pending_chunks.push_back(ch);
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // response side: random stalls, compare each beat against the oldest expectation
  initial begin
    int stall;
    chunk_t w;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_chunks.size() == 0) begin
          report_mismatch("unexpected beat", rsp_ch.tx_chunk, 64'd0);
        end else begin
          w = pending_chunks.pop_front();
          if (rsp_ch.tx_chunk !== w.chunk) report_mismatch("tx_chunk", rsp_ch.tx_chunk, w.chunk);
          if (rsp_ch.tx_chunk_bytes !== w.nbytes)
            report_mismatch("tx_chunk_bytes", rsp_ch.tx_chunk_bytes, w.nbytes);
          if (rsp_ch.tx_last !== w.last) report_mismatch("tx_last", rsp_ch.tx_last, w.last);
        end
      end
      if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // valid stays high after a beat; the next call or drain replaces or drops it
  task automatic send_item(input logic [1:0] rt, input logic [7:0] b = 8'd0,
                           input logic [5:0] idx = 6'd0, input logic [15:0] val = 16'd0);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.rx_byte <= b;
    req_ch.input_reg_index <= idx;
    req_ch.input_reg_value <= val;
    do @(posedge clk_i); while (!req_ch.ready);
    predict_item(rt, b, idx, val);
  endtask

  task automatic send_frame(input logic [7:0] f[$], input bit good_crc = 1'b1);
    logic [15:0] c;
    c = crc_of(f);
    if (!good_crc) c = ~c;
    foreach (f[i]) send_item(REQ_BYTE, f[i]);
    send_item(REQ_BYTE, c[7:0]);
    send_item(REQ_BYTE, c[15:8]);
    send_item(REQ_GAP);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_chunks.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  task automatic set_address(input logic [7:0] a);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    own_addr = a;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_addr();
    int r;
    r = $urandom_range(0, 9);
    return r < 6 ? own_addr : (r < 8 ? 8'd0 : 8'($urandom));
  endfunction

  task automatic test_directed();
    send_frame({8'd1, FC_WR_ONE, 8'd0, 8'd5, 8'hFF, 8'hFF});
    send_frame({8'd1, FC_WR_MULTI, 8'd0, 8'd62, 8'd0, 8'd2, 8'd4, 8'h12, 8'h34, 8'hAB, 8'hCD});
    send_item(REQ_INREG, 8'd0, 6'd63, 16'hFFFF);
    send_item(REQ_INREG, 8'd0, 6'd0, 16'h5A5A);
    send_frame({8'd1, FC_RD_HOLD, 8'd0, 8'd0, 8'd0, 8'd64});
    send_frame({8'd1, FC_RD_INPUT, 8'd0, 8'd0, 8'd0, 8'd64});
    send_frame({8'd1, FC_RD_INPUT, 8'd0, 8'd1, 8'd0, 8'd64});
    send_frame({8'd1, FC_RD_HOLD, 8'd0, 8'd0, 8'd0, 8'd0});
    send_frame({8'd1, FC_RD_HOLD, 8'd0, 8'd0, 8'd0, 8'd126});
    send_frame({8'd1, FC_RD_HOLD, 8'd0, 8'd0});
    send_frame({8'd1, FC_WR_ONE, 8'd0, 8'd64, 8'd0, 8'd1});
    send_frame({8'd1, FC_WR_MULTI, 8'd0, 8'd0, 8'd0, 8'd2, 8'd3, 8'd1, 8'd2, 8'd3});
    send_frame({8'd1, 8'd7, 8'd0});
    send_frame({8'd0, FC_WR_ONE, 8'd0, 8'd9, 8'hBE, 8'hEF});
    send_frame({8'd0, FC_RD_HOLD, 8'd0, 8'd9, 8'd0, 8'd1});
    send_frame({8'd0, 8'd99, 8'd0});
    send_frame({8'd2, FC_RD_HOLD, 8'd0, 8'd9, 8'd0, 8'd1});
    send_frame({8'd1, FC_RD_HOLD, 8'd0, 8'd9, 8'd0, 8'd1}, 1'b0);
    send_item(REQ_BYTE, 8'd1);
    send_item(REQ_BYTE, 8'd3);
    send_item(REQ_GAP);
    send_frame({8'd1, FC_RD_HOLD, 8'd0, 8'd9, 8'd0, 8'd1});
  endtask

  task automatic test_buffer_full();
    // 257 bytes: the last one clears the buffer, then a good frame follows
    for (int i = 0; i < FRAME_BYTES + 1; i++) send_item(REQ_BYTE, 8'($urandom));
    send_frame({8'd1, FC_RD_INPUT, 8'd0, 8'd0, 8'd0, 8'd2});
  endtask

  task automatic test_random(input int n);
    logic [7:0] f[$];
    logic [7:0] fc;
    int start, count, kind;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 19);
      start = $urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 66);
      count = $urandom_range(0, 9) == 0 ? $urandom_range(0, 130) : $urandom_range(1, 8);
      if (kind < 2) begin
        send_item(REQ_INREG, 8'($urandom), 6'($urandom), 16'($urandom));
      end else if (kind < 3) begin
        repeat ($urandom_range(0, 6)) send_item(REQ_BYTE, 8'($urandom));
        send_item(REQ_GAP);
      end else begin
        fc = kind < 7 ? FC_RD_HOLD : kind < 10 ? FC_RD_INPUT : kind < 13 ? FC_WR_ONE :
             kind < 18 ? FC_WR_MULTI : 8'($urandom);
        f = {pick_addr(), fc, 8'(start >> 8), 8'(start), 8'(count >> 8), 8'(count)};
        if (fc == FC_WR_ONE) begin
          f[4] = 8'($urandom);
          f[5] = 8'($urandom);
        end
        if (fc == FC_WR_MULTI) begin
          f.push_back($urandom_range(0, 7) == 0 ? 8'($urandom) : 8'(count * 2));
          for (int i = 0; i < 2 * count && i < 40; i++) f.push_back(8'($urandom));
        end
        if ($urandom_range(0, 9) == 0) f = f[0:$urandom_range(0, f.size() - 1)];
        send_frame(f, $urandom_range(0, 15) != 0);
      end
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_BYTE;
    req_ch.rx_byte = 8'd0;
    req_ch.input_reg_index = 6'd0;
    req_ch.input_reg_value = 16'd0;
    flen = 0;
    own_addr = 8'd1;
    foreach (hold_regs[i]) begin hold_regs[i] = '0; in_regs[i] = '0; end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_buffer_full();
    set_address(8'd247);
    test_random(2);
    set_address(8'($urandom_range(2, 246)));
    test_random(2);
    set_address(8'd1);
    test_random(1);
    calm = 1'b1;
    test_random(2);
    drain();
    if (errors == 0) $display("modbus_rtu_slave_frame_engine regression: pass");
    else $display("modbus_rtu_slave_frame_engine regression: fail");
    $finish;
  end
endmodule
